@@ design/plct_pkg.sv @@
package plct_pkg;

  // field widths fixed by the interface
  localparam int CMD_W  = 2;
  localparam int CH_W   = 4;
  localparam int CNT_W  = 8;
  localparam int DATA_W = 32;
  localparam int STAT_W = 3;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CONVERT = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_COUNT     = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_OVERWRITE = 3'd3;
  localparam logic [STAT_W-1:0] ST_EQUAL_X   = 3'd4;

  // one segment table row
  typedef struct packed {
    logic signed [DATA_W-1:0] brk;
    logic signed [DATA_W-1:0] offset;
    logic signed [DATA_W-1:0] slope;
  } seg_entry_t;

  // divider handshake towards the sequencer
  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ design/plct_ram.sv @@
module plct_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/plct_div.sv @@
module plct_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [64:0]   dividend,
  input  logic signed [32:0]   divisor,
  output plct_pkg::div_rsp_t   rsp
);
  import plct_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] q_r;
  logic [32:0] rem_r;
  logic [32:0] dvs_r;
  logic        neg_r;

  logic [64:0] dvd_abs;
  logic [32:0] dvs_abs;
  logic [33:0] rem_sh;
  logic        take;

  assign dvd_abs = dividend[64] ? 65'(-dividend) : 65'(dividend);
  assign dvs_abs = divisor[32] ? 33'(-divisor) : 33'(divisor);

  // one restoring step per cycle
  assign rem_sh = {rem_r, q_r[63]};
  assign take   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= dvd_abs[63:0];
        rem_r  <= '0;
        dvs_r  <= dvs_abs;
        neg_r  <= dividend[64] ^ divisor[32];
      end else if (busy_r) begin
        rem_r <= take ? 33'(rem_sh - {1'b0, dvs_r}) : rem_sh[32:0];
        q_r   <= {q_r[62:0], take};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // truncated quotient, saturated to 32 bits signed
  always_comb begin
    rsp.done = done_r;
    if (neg_r) begin
      if (q_r > 64'h0000_0000_8000_0000) begin
        rsp.quot = 32'sh8000_0000;
      end else begin
        rsp.quot = 32'(-q_r);
      end
    end else begin
      if (q_r > 64'h0000_0000_7FFF_FFFF) begin
        rsp.quot = 32'sh7FFF_FFFF;
      end else begin
        rsp.quot = q_r[31:0];
      end
    end
  end

endmodule

@@ design/piecewise_linear_calibration_table_core.sv @@
// Piecewise-linear calibration engine, one command beat in, one result beat out.
// Input channel: in_valid/in_stall with cmd, channel, point_count, segment_number,
// two calibration points and a sample. Result channel: out_valid/out_stall with
// status and value. A beat moves when valid is high and stall is low.
// The block takes one command at a time; in_stall is high while it works.
// Steps from the accepting edge to the edge that loads the result register:
//   allocate, errors, passthrough and invalid channel: settled in dispatch
//   set point: two 64-step serial divisions in the shared divider
//              plus two passes through the multiplier
//   convert  : compares segment by segment until segment n of the run matches,
//              or uses the last segment of the run when no breakpoint matches
// A new command is accepted only after the result is loaded, so commands
// never overlap.
// The result sits in an output register; the next command is accepted while it
// waits, and that command's result is held back until the receiver takes it.
// Reset (rst_n low, synchronous) clears the channel allocation and marks every
// segment table row as unwritten, so it reads as zero; no clearing pass is run.
module piecewise_linear_calibration_table_core #(
  parameter int CHANNELS = 8,
  parameter int SEGMENTS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [plct_pkg::CMD_W-1:0]         in_cmd,
  input  logic [plct_pkg::CH_W-1:0]          in_channel,
  input  logic [plct_pkg::CNT_W-1:0]         in_point_count,
  input  logic [plct_pkg::CNT_W-1:0]         in_segment_number,
  input  logic signed [plct_pkg::DATA_W-1:0] in_x_first,
  input  logic signed [plct_pkg::DATA_W-1:0] in_y_first,
  input  logic signed [plct_pkg::DATA_W-1:0] in_x_second,
  input  logic signed [plct_pkg::DATA_W-1:0] in_y_second,
  input  logic signed [plct_pkg::DATA_W-1:0] in_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [plct_pkg::STAT_W-1:0]        out_status,
  output logic signed [plct_pkg::DATA_W-1:0] out_value
);
  import plct_pkg::*;

  localparam int CI_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SA_W  = $clog2(SEGMENTS);
  localparam int SEG_W = $clog2(SEGMENTS + 1);
  localparam int IW    = ((SEG_W > CNT_W) ? SEG_W : CNT_W) + 1;
  localparam int ENT_W = $bits(seg_entry_t);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_MUL1, S_MUL2, S_DIVS, S_WAITS, S_DIVO, S_WAITO, S_WR,
    S_CRD, S_CCMP, S_SRD, S_SMUL, S_SADD, S_FIN
  } state_t;

  state_t state_r;

  // latched command
  logic [CMD_W-1:0]         cmd_r;
  logic [CH_W-1:0]          ch_r;
  logic [CNT_W-1:0]         cnt_in_r;
  logic [CNT_W-1:0]         seg_in_r;
  logic signed [DATA_W-1:0] x1_r, y1_r, x2_r, y2_r, smp_r;

  // channel allocation
  logic [SEG_W-1:0] base_r [CHANNELS];
  logic [CNT_W-1:0] ccnt_r [CHANNELS];
  logic [SEG_W-1:0] nfs_r;
  logic             seg_vld_r [SEGMENTS];

  // working registers
  logic [IW-1:0]            idx_r;
  logic [IW-1:0]            lim_r;
  logic [IW-1:0]            last_r;
  logic [SA_W-1:0]          widx_r;
  logic signed [63:0]       prod_r;
  logic signed [63:0]       prod1_r;
  logic signed [63:0]       prod2_r;
  logic signed [DATA_W-1:0] slope_r;
  logic signed [DATA_W-1:0] off_r;
  logic [STAT_W-1:0]        res_st_r;
  logic signed [DATA_W-1:0] res_val_r;
  logic                     out_valid_r;
  logic [STAT_W-1:0]        out_status_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     rd_vld_r;

  // table port
  logic                     ram_we;
  logic [SA_W-1:0]          ram_raddr;
  logic [ENT_W-1:0]         ram_rdata;
  seg_entry_t               ram_wdata;
  seg_entry_t               entry;

  // shared units
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic                     div_start;
  logic signed [64:0]       div_dvd;
  logic signed [32:0]       div_dvs;
  div_rsp_t                 div_rsp;

  // decode of the latched command
  logic             ch_ok;
  logic [CI_W-1:0]  ci;
  logic [SEG_W-1:0] cbase;
  logic [CNT_W-1:0] ccnt;
  logic [IW-1:0]    alloc_end;
  logic [IW-1:0]    set_idx;
  logic [IW-1:0]    run_end;
  logic [IW-1:0]    idx_inc;
  logic signed [32:0] dy;
  logic signed [32:0] dx_neg;
  logic signed [47:0] fl;
  logic signed [48:0] sum;
  logic signed [DATA_W-1:0] sum_sat;

  assign ch_ok     = {1'b0, ch_r} < (CH_W + 1)'(CHANNELS);
  assign ci        = CI_W'(ch_r);
  assign cbase     = base_r[ci];
  assign ccnt      = ccnt_r[ci];
  assign alloc_end = IW'(cnt_in_r) + IW'(nfs_r);
  assign set_idx   = IW'(cbase) + IW'(seg_in_r);
  assign run_end   = IW'(cbase) + IW'(ccnt);
  assign idx_inc   = idx_r + IW'(1);
  assign dy        = 33'(y1_r) - 33'(y2_r);
  assign dx_neg    = 33'(x2_r) - 33'(x1_r);

  // unwritten rows read as zero
  assign entry = rd_vld_r ? seg_entry_t'(ram_rdata) : '0;

  // multiplier operand selection
  always_comb begin
    case (state_r)
      S_MUL1: begin
        mul_a = y1_r;
        mul_b = x2_r;
      end
      S_MUL2: begin
        mul_a = y2_r;
        mul_b = x1_r;
      end
      default: begin
        mul_a = entry.slope;
        mul_b = smp_r;
      end
    endcase
  end

  // divider operands: slope first, offset second
  always_comb begin
    div_start = (state_r == S_DIVS) || (state_r == S_DIVO);
    if (state_r == S_DIVS) begin
      div_dvd = {{16{dy[32]}}, dy, 16'b0};
      div_dvs = -dx_neg;
    end else begin
      div_dvd = 65'(prod1_r) - 65'(prod2_r);
      div_dvs = dx_neg;
    end
  end

  // floor(slope*sample / 2^16) + offset, saturated
  assign fl  = prod_r[63:16];
  assign sum = 49'(fl) + 49'(off_r);
  always_comb begin
    if (sum > 49'sh0_7FFF_FFFF) begin
      sum_sat = 32'sh7FFF_FFFF;
    end else if (sum < -49'sh0_8000_0000) begin
      sum_sat = 32'sh8000_0000;
    end else begin
      sum_sat = sum[31:0];
    end
  end

  // table read address
  always_comb begin
    ram_raddr = (state_r == S_SRD) ? SA_W'(last_r) : SA_W'(idx_r);
  end

  assign ram_we           = (state_r == S_WR);
  assign ram_wdata.slope  = slope_r;
  assign ram_wdata.offset = div_rsp.quot;
  assign ram_wdata.brk    = x2_r;

  plct_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SEGMENTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  plct_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .rsp      (div_rsp)
  );

  // multiplier and row valid read, registered
  always_ff @(posedge clk) begin
    prod_r   <= 64'(mul_a) * 64'(mul_b);
    rd_vld_r <= seg_vld_r[ram_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      nfs_r       <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        base_r[i] <= '0;
        ccnt_r[i] <= '0;
      end
      for (int i = 0; i < SEGMENTS; i++) begin
        seg_vld_r[i] <= 1'b0;
      end
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r    <= in_cmd;
            ch_r     <= in_channel;
            cnt_in_r <= in_point_count;
            seg_in_r <= in_segment_number;
            x1_r     <= in_x_first;
            y1_r     <= in_y_first;
            x2_r     <= in_x_second;
            y2_r     <= in_y_second;
            smp_r    <= in_sample;
            state_r  <= S_DISP;
          end
        end
        S_DISP: begin
          res_st_r  <= ST_OK;
          res_val_r <= '0;
          state_r   <= S_FIN;
          case (cmd_r)
            CMD_ALLOC: begin
              if (!ch_ok) begin
                res_st_r <= ST_OVERWRITE;
              end else if (cnt_in_r == CNT_W'(1)) begin
                res_st_r <= ST_COUNT;
              end else if (ccnt == '0) begin
                if (alloc_end > IW'(SEGMENTS)) begin
                  res_st_r <= ST_FULL;
                end else begin
                  ccnt_r[ci] <= cnt_in_r;
                  base_r[ci] <= nfs_r;
                  nfs_r      <= SEG_W'(alloc_end);
                end
              end else if ((IW'(ccnt) + IW'(1)) != IW'(cnt_in_r)) begin
                res_st_r <= ST_OVERWRITE;
              end
            end
            CMD_SET: begin
              if (!ch_ok || (seg_in_r >= ccnt) || (set_idx >= IW'(SEGMENTS))) begin
                res_st_r <= ST_OVERWRITE;
              end else if (x1_r == x2_r) begin
                res_st_r <= ST_EQUAL_X;
              end else begin
                widx_r  <= SA_W'(set_idx);
                state_r <= S_MUL1;
              end
            end
            CMD_CONVERT: begin
              if (ch_ok) begin
                if (ccnt == '0) begin
                  res_val_r <= smp_r;
                end else begin
                  idx_r   <= IW'(cbase);
                  lim_r   <= (run_end < IW'(SEGMENTS)) ? run_end : IW'(SEGMENTS);
                  last_r  <= (run_end - IW'(1) < IW'(SEGMENTS)) ?
                             (run_end - IW'(1)) : IW'(SEGMENTS - 1);
                  state_r <= S_CRD;
                end
              end
            end
            default: begin
              res_st_r <= ST_OK;
            end
          endcase
        end
        // set point: y1*x2, then y2*x1, then two divisions
        S_MUL1: state_r <= S_MUL2;
        S_MUL2: begin
          prod1_r <= prod_r;
          state_r <= S_DIVS;
        end
        S_DIVS: begin
          prod2_r <= prod_r;
          state_r <= S_WAITS;
        end
        S_WAITS: begin
          if (div_rsp.done) begin
            slope_r <= div_rsp.quot;
            state_r <= S_DIVO;
          end
        end
        S_DIVO: state_r <= S_WAITO;
        S_WAITO: begin
          if (div_rsp.done) begin
            state_r <= S_WR;
          end
        end
        S_WR: begin
          seg_vld_r[widx_r] <= 1'b1;
          state_r           <= S_FIN;
        end
        // convert: walk the run for the first breakpoint at or above the sample
        S_CRD: begin
          if (idx_r >= lim_r) begin
            state_r <= S_SRD;
          end else begin
            state_r <= S_CCMP;
          end
        end
        S_CCMP: begin
          if (smp_r <= entry.brk) begin
            last_r  <= idx_r;
            state_r <= S_SRD;
          end else begin
            idx_r   <= idx_inc;
            state_r <= S_CRD;
          end
        end
        S_SRD:  state_r <= S_SMUL;
        S_SMUL: begin
          off_r   <= entry.offset;
          state_r <= S_SADD;
        end
        S_SADD: begin
          res_val_r <= sum_sat;
          state_r   <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_st_r;
            out_value_r  <= res_val_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;

endmodule

@@ design/plct_checker.sv @@
module plct_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [plct_pkg::STAT_W-1:0]        out_status,
  input logic signed [plct_pkg::DATA_W-1:0] out_value
);
  import plct_pkg::*;

  // a held result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // status stays within the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_EQUAL_X))
    else $error("status code out of range");

  // an accepted command keeps the block busy next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block ready right after accepting a command");

  // any error status carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_value == '0))
    else $error("error status with non-zero value");

endmodule

bind piecewise_linear_calibration_table_core plct_checker u_plct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_status (out_status),
  .out_value  (out_value)
);
